// ===== rtl/lkv_pkg.sv =====
// Shared constants for the LRU key-value cache: sizes, widths, operation codes
// and the configuration register map.
// No dependencies; the interfaces and the top level take names from here.
package lkv_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CAP_W       = 5;

  // APB register map: one 32-bit register per word
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned REG_IDX_W   = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -VAL_W'(1);

endpackage

// ===== rtl/lkv_stream_if.sv =====
// Valid/ready channel interfaces for the LRU key-value cache: one for
// requests (get or put), one for results. Depends on lkv_pkg for widths.
interface lkv_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [lkv_pkg::KEY_W-1:0]   lookup_key;
  logic signed [lkv_pkg::VAL_W-1:0]   write_value;

  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lkv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [lkv_pkg::VAL_W-1:0]   read_value;
  logic                               evicted;
  logic signed [lkv_pkg::KEY_W-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/lru_key_value_cache.sv =====
// A result is registered once its request has been scanned and resolved. One
// request is handled at a time; the next is accepted after the result is registered.
// The scan sets the pace: one shared key comparator walks all entries,
// one per cycle, behind the registered read of the key and value memories.
// Reset (rst_n, synchronous, active low) clears valid marks, ranks, fill count
// and the output valid, and sets capacity to 16; key/value memories are not cleared.
module lru_key_value_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  lkv_req_if.sink                             in_ch,
  lkv_rsp_if.source                           out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkv_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lkv_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lkv_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  localparam int unsigned N   = lkv_pkg::MAX_ENTRIES;
  localparam int unsigned IW  = lkv_pkg::IDX_W;
  localparam int unsigned CW  = lkv_pkg::CNT_W;
  localparam int unsigned KW  = lkv_pkg::KEY_W;
  localparam int unsigned VW  = lkv_pkg::VAL_W;

  state_t                     state_r;
  logic [lkv_pkg::CAP_W-1:0]  cap_r;
  logic [N-1:0]               valid_r;
  logic [IW-1:0]              rank_r [N];
  logic [IW-1:0]              rank_nxt [N];
  logic [CW-1:0]              fill_r;
  logic [CW-1:0]              cnt_r;

  // latched request
  logic                       mode_r;
  logic signed [KW-1:0]       key_r;
  logic signed [VW-1:0]       wval_r;

  // memories and their registered read data
  logic signed [KW-1:0]       key_mem_r [N];
  logic signed [VW-1:0]       val_mem_r [N];
  logic signed [KW-1:0]       key_q_r;
  logic signed [VW-1:0]       val_q_r;
  logic                       chk_vld_r;
  logic [IW-1:0]              chk_idx_r;

  // scan results
  logic                       found_r;
  logic [IW-1:0]              found_idx_r;
  logic [IW-1:0]              found_rank_r;
  logic signed [VW-1:0]       found_val_r;
  logic                       free_r;
  logic [IW-1:0]              free_idx_r;
  logic [IW-1:0]              victim_idx_r;
  logic signed [KW-1:0]       victim_key_r;

  // result register
  logic                       out_valid_r;
  logic                       hit_r;
  logic signed [VW-1:0]       rval_r;
  logic                       evicted_r;
  logic signed [KW-1:0]       evk_r;

  logic [CW-1:0]              eff_cap;
  logic [CW-1:0]              fill_m1;
  logic                       has_room;
  logic                       is_put;
  logic                       do_touch;
  logic                       do_fill;
  logic                       do_evict;
  logic [IW-1:0]              tgt_idx;
  logic [IW-1:0]              touch_rank;
  logic                       resolve_go;
  logic                       mem_we;
  logic                       cfg_we;
  logic                       chk_entry_vld;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[lkv_pkg::APB_ADDR_W-1:2] == lkv_pkg::REG_CAPACITY);
  assign prdata = (paddr[lkv_pkg::APB_ADDR_W-1:2] == lkv_pkg::REG_CAPACITY)
                  ? lkv_pkg::APB_DATA_W'(cap_r) : '0;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_r) > CW'(N)) begin
      eff_cap = CW'(N);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  // ---------------------------------------------------------------- decision
  assign fill_m1    = fill_r - CW'(1);
  assign has_room   = fill_r < eff_cap;
  assign is_put     = (mode_r == lkv_pkg::MODE_PUT);
  assign do_fill    = is_put && !found_r && has_room;
  assign do_evict   = is_put && !found_r && !has_room;
  assign do_touch   = found_r || do_evict;
  assign tgt_idx    = found_r ? found_idx_r : (has_room ? free_idx_r : victim_idx_r);
  assign touch_rank = found_r ? found_rank_r : fill_m1[IW-1:0];
  assign resolve_go = (state_r == ST_RESOLVE) && (!out_valid_r || out_ch.ready);
  assign mem_we     = resolve_go && is_put;
  assign chk_entry_vld = valid_r[chk_idx_r];

  // age entries more recent than the target, then make the target most recent
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch && valid_r[i] && (IW'(i) != tgt_idx) && (rank_r[i] < touch_rank)) begin
        rank_nxt[i] = rank_r[i] + IW'(1);
      end
      if (do_fill && valid_r[i]) begin
        rank_nxt[i] = rank_r[i] + IW'(1);
      end
      if ((do_touch || do_fill) && (IW'(i) == tgt_idx)) begin
        rank_nxt[i] = '0;
      end
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem_r[tgt_idx] <= key_r;
      val_mem_r[tgt_idx] <= wval_r;
    end
    key_q_r <= key_mem_r[cnt_r[IW-1:0]];
    val_q_r <= val_mem_r[cnt_r[IW-1:0]];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= lkv_pkg::CAP_RESET;
      valid_r     <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= pwdata[lkv_pkg::CAP_W-1:0];
      end
      if (out_valid_r && out_ch.ready && !resolve_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            mode_r    <= in_ch.mode;
            key_r     <= in_ch.lookup_key;
            wval_r    <= in_ch.write_value;
            cnt_r     <= '0;
            chk_vld_r <= 1'b0;
            found_r   <= 1'b0;
            free_r    <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // entry chk_idx_r was read last cycle; compare it now
          if (chk_vld_r) begin
            if (chk_entry_vld && (key_q_r == key_r) && !found_r) begin
              found_r      <= 1'b1;
              found_idx_r  <= chk_idx_r;
              found_rank_r <= rank_r[chk_idx_r];
              found_val_r  <= val_q_r;
            end
            if (!chk_entry_vld && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
            if (chk_entry_vld && (rank_r[chk_idx_r] == fill_m1[IW-1:0])) begin
              victim_idx_r <= chk_idx_r;
              victim_key_r <= key_q_r;
            end
          end
          chk_vld_r <= (cnt_r < CW'(N));
          chk_idx_r <= cnt_r[IW-1:0];
          cnt_r     <= cnt_r + CW'(1);
          if (cnt_r == CW'(N)) begin
            state_r <= ST_RESOLVE;
          end
        end

        ST_RESOLVE: begin
          // hold until the result register is free
          if (resolve_go) begin
            rank_r      <= rank_nxt;
            if (do_fill) begin
              valid_r[tgt_idx] <= 1'b1;
              fill_r           <= fill_r + CW'(1);
            end
            out_valid_r <= 1'b1;
            hit_r       <= found_r;
            rval_r      <= is_put ? '0 : (found_r ? found_val_r : lkv_pkg::MISS_VALUE);
            evicted_r   <= do_evict;
            evk_r       <= do_evict ? victim_key_r : '0;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.read_value  = rval_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = evk_r;

`ifndef NO_ASSERTIONS
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == CW'($countones(valid_r)))
    else $error("fill count differs from number of valid entries");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE && found_r) |-> valid_r[found_idx_r])
    else $error("hit resolved on an invalid entry");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (resolve_go && do_fill) |-> (fill_r < CW'(N)))
    else $error("fill past the last entry");
`endif

endmodule

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed table, then random
// get/put traffic over several capacities with random stalls on both channels.
// Depends on lkv_pkg, lkv_req_if/lkv_rsp_if and the top level in rtl/.
module lru_key_value_cache_tb;

  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned STALL_PCT    = 11;

  localparam logic [lkv_pkg::REG_IDX_W-1:0] REG_UNMAPPED = lkv_pkg::REG_IDX_W'(1);

  localparam logic signed [lkv_pkg::KEY_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [lkv_pkg::KEY_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [lkv_pkg::KEY_W-1:0] WORD_NEG = -32'sd1;

  typedef struct packed {
    logic                             hit;
    logic signed [lkv_pkg::VAL_W-1:0] read_value;
    logic                             evicted;
    logic signed [lkv_pkg::KEY_W-1:0] evicted_key;
  } lookup_result_t;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

  // for ROW_CFG rows, value holds the register data
  typedef struct packed {
    row_kind_t                        kind;
    logic                             mode;
    logic [lkv_pkg::REG_IDX_W-1:0]    reg_idx;
    logic signed [lkv_pkg::KEY_W-1:0] key;
    logic signed [lkv_pkg::VAL_W-1:0] value;
    logic                             typed;
    lookup_result_t                   expected;
  } stim_row_t;

  localparam lookup_result_t GET_MISS = '{1'b0, lkv_pkg::MISS_VALUE, 1'b0, 32'sd0};
  localparam lookup_result_t PUT_NEW  = '{1'b0, 32'sd0, 1'b0, 32'sd0};
  localparam lookup_result_t PUT_HIT  = '{1'b1, 32'sd0, 1'b0, 32'sd0};

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lkv_pkg::APB_ADDR_W-1:0] paddr;
  logic [lkv_pkg::APB_DATA_W-1:0] pwdata;
  logic [lkv_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // cache image
  logic [lkv_pkg::KEY_W-1:0] mdl_key   [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] mdl_value [lkv_pkg::MAX_ENTRIES];
  bit                        mdl_valid [lkv_pkg::MAX_ENTRIES];
  int unsigned               mdl_rank  [lkv_pkg::MAX_ENTRIES];
  int unsigned               mdl_fill;
  logic [lkv_pkg::CAP_W-1:0] mdl_cap;

  lookup_result_t result_queue[$];
  logic [lkv_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit no_stall;

  stim_row_t directed_rows [0:24] = '{
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd0,   1'b1, GET_MISS},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, WORD_MIN, 32'sd0,   1'b1, GET_MISS},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, WORD_MAX, WORD_MIN, 1'b1, PUT_NEW},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, WORD_MIN, WORD_MAX, 1'b1, PUT_NEW},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd0,   WORD_NEG, 1'b1, PUT_NEW},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, WORD_NEG, 32'sd0,   1'b1, PUT_NEW},
    // stored -1 comes back with hit set
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd0,   1'b1,
      '{1'b1, WORD_NEG, 1'b0, 32'sd0}},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, WORD_MAX, 32'sd0,   1'b1,
      '{1'b1, WORD_MIN, 1'b0, 32'sd0}},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, WORD_MIN, 32'sd0,   1'b1,
      '{1'b1, WORD_MAX, 1'b0, 32'sd0}},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, WORD_MAX, 32'sd12345, 1'b1,
      PUT_HIT},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd1,   32'sd0,   1'b1, GET_MISS},
    // shrink below the fill count: nothing dropped, puts replace
    '{ROW_CFG, lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd2,   1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd1,   32'sh55,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd2,   32'shAA,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd1,   32'sd0,   1'b0, '0},
    // zero capacity acts as one
    '{ROW_CFG, lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd0,   1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd3,   32'sd3,   1'b0, '0},
    // write to an unmapped register must leave capacity alone
    '{ROW_CFG, lkv_pkg::MODE_GET, REG_UNMAPPED,          32'sd0,   32'sd16,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd4,   32'sd4,   1'b0, '0},
    // capacity above the entry count acts as the entry count
    '{ROW_CFG, lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd31,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd5,   -32'sd5,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_PUT, lkv_pkg::REG_CAPACITY, 32'sd6,   32'sd6,   1'b0, '0},
    '{ROW_CFG, lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd0,   32'sd16,  1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd5,   32'sd0,   1'b0, '0},
    '{ROW_OP,  lkv_pkg::MODE_GET, lkv_pkg::REG_CAPACITY, 32'sd3,   32'sd0,   1'b0, '0}
  };

  int unsigned phase_caps [8] = '{16, 1, 4, 31, 0, 8, 3, 12};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Make an entry most recent; valid entries that were more recent age by one.
  function automatic void promote_entry(input int slot);
    int unsigned old_rank;
    old_rank = mdl_rank[slot];
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (mdl_valid[i] && i != slot && mdl_rank[i] < old_rank) mdl_rank[i]++;
    mdl_rank[slot] = 0;
  endfunction

  function automatic lookup_result_t cache_access(input logic mode,
                                                  input logic [lkv_pkg::KEY_W-1:0] key,
                                                  input logic [lkv_pkg::VAL_W-1:0] value);
    lookup_result_t res;
    int found;
    int slot;
    int unsigned limit;
    int unsigned oldest;
    res    = '0;
    found  = -1;
    slot   = -1;
    oldest = 0;
    limit  = (mdl_cap == 0) ? 1 :
             ((mdl_cap > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES : mdl_cap);
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (found < 0 && mdl_valid[i] && mdl_key[i] == key) found = i;

    if (mode == lkv_pkg::MODE_GET) begin
      if (found >= 0) begin
        res.hit        = 1'b1;
        res.read_value = mdl_value[found];
        promote_entry(found);
      end else begin
        res.read_value = lkv_pkg::MISS_VALUE;
      end
    end else if (found >= 0) begin
      res.hit          = 1'b1;
      mdl_value[found] = value;
      promote_entry(found);
    end else if (mdl_fill < limit) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        if (slot < 0 && !mdl_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
          if (mdl_valid[i]) mdl_rank[i]++;
        mdl_valid[slot] = 1'b1;
        mdl_key[slot]   = key;
        mdl_value[slot] = value;
        mdl_rank[slot]  = 0;
        mdl_fill++;
      end
    end else begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        if (mdl_valid[i] && (slot < 0 || mdl_rank[i] > oldest)) begin
          slot   = i;
          oldest = mdl_rank[i];
        end
      if (slot >= 0) begin
        res.evicted     = 1'b1;
        res.evicted_key = mdl_key[slot];
        mdl_key[slot]   = key;
        mdl_value[slot] = value;
        promote_entry(slot);
      end
    end
    return res;
  endfunction

  // Starts from a posedge or time 0; returns at the posedge of acceptance.
  task automatic run_request(input logic mode, input logic [lkv_pkg::KEY_W-1:0] key,
                             input logic [lkv_pkg::VAL_W-1:0] value, input logic typed,
                             input lookup_result_t typed_result);
    lookup_result_t predicted;
    @(negedge clk);
    while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.lookup_key  <= key;
    req_ch.write_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    predicted = cache_access(mode, key, value);
    result_queue.push_back(typed ? typed_result : predicted);
  endtask

  // Drain the cache, write one register, then read capacity back.
  task automatic write_register(input logic [lkv_pkg::REG_IDX_W-1:0] idx,
                                input logic [lkv_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lkv_pkg::REG_CAPACITY) mdl_cap = data[lkv_pkg::CAP_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    paddr   <= {lkv_pkg::REG_CAPACITY, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== lkv_pkg::APB_DATA_W'(mdl_cap))
      report_error($sformatf("capacity readback: got %0d expected %0d", prdata, mdl_cap));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: stall at random, drive at the falling edge
  always @(negedge clk) begin
    rsp_ch.ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    lookup_result_t exp_res;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (result_queue.size() == 0) begin
        report_error("result transaction with no request outstanding");
      end else begin
        exp_res = result_queue.pop_front();
        if (rsp_ch.hit !== exp_res.hit)
          report_error($sformatf("hit: got %b expected %b", rsp_ch.hit, exp_res.hit));
        if (rsp_ch.read_value !== exp_res.read_value)
          report_error($sformatf("read_value: got %0d expected %0d",
                                 rsp_ch.read_value, exp_res.read_value));
        if (rsp_ch.evicted !== exp_res.evicted)
          report_error($sformatf("evicted: got %b expected %b",
                                 rsp_ch.evicted, exp_res.evicted));
        if (rsp_ch.evicted_key !== exp_res.evicted_key)
          report_error($sformatf("evicted_key: got %0d expected %0d",
                                 rsp_ch.evicted_key, exp_res.evicted_key));
      end
    end
  end

  // watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("lru_key_value_cache test failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] value;
    int unsigned span;
    int unsigned eff_cap;
    clk                = 1'b0;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = lkv_pkg::MODE_GET;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    rsp_ch.ready       = 1'b1;
    error_count        = 0;
    quiet_cycles       = 0;
    no_stall           = 1'b0;
    mdl_fill           = 0;
    mdl_cap            = lkv_pkg::CAP_RESET;
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
      mdl_key[i]   = '0;
      mdl_value[i] = '0;
      mdl_valid[i] = 1'b0;
      mdl_rank[i]  = 0;
    end
    key_pool[0] = WORD_MIN;
    key_pool[1] = WORD_MAX;
    key_pool[2] = '0;
    key_pool[3] = WORD_NEG;
    key_pool[4] = 32'd1;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < $size(directed_rows); n++) begin
      row = directed_rows[n];
      if (row.kind == ROW_CFG)
        write_register(row.reg_idx, row.value);
      else
        run_request(row.mode, row.key, row.value, row.typed, row.expected);
    end

    for (int p = 0; p < $size(phase_caps); p++) begin
      write_register(lkv_pkg::REG_CAPACITY, phase_caps[p]);
      no_stall = (p == 3);
      eff_cap  = (phase_caps[p] == 0) ? 1 :
                 ((phase_caps[p] > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES :
                  phase_caps[p]);
      // keep the key set a little larger than capacity to mix hits and replacements
      span = (eff_cap + 3 > POOL_SIZE) ? POOL_SIZE : eff_cap + 3;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 6) key = $urandom;
        else key = key_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 19))
          0: value = WORD_MIN;
          1: value = WORD_MAX;
          2: value = WORD_NEG;
          3: value = '0;
          default: value = $urandom;
        endcase
        run_request($urandom_range(0, 1) ? lkv_pkg::MODE_PUT : lkv_pkg::MODE_GET,
                    key, value, 1'b0, '0);
      end
    end
    no_stall = 1'b0;

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
